/* src/kms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_pkg
// Types, constants and helpers shared by the keypad matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int ROWS = 4;   // 2..4
  localparam int COLS = 4;   // 2..4

  localparam int RW = 2;     // row / column index width (key_row, key_col)
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [15:0] PRESS_DB_RST   = 16'd20;
  localparam logic [15:0] RELEASE_DB_RST = 16'd20;
  localparam logic [31:0] STUCK_LIM_RST  = 32'd5000;
  localparam logic [63:0] KEY_CODES_RST  = 64'hDEF0_C987_B654_A321;

  // per-key debounce state
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_PRESS_PEND = 3'd1,
    ST_PRESSED    = 3'd2,
    ST_HELD       = 3'd3,
    ST_REL_PEND   = 3'd4
  } st_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_GHOST   = 2'd2,
    EV_STUCK   = 2'd3
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_DB   = 3'd0,
    REG_RELEASE_DB = 3'd1,
    REG_GHOST_ON   = 3'd2,
    REG_STUCK_ON   = 3'd3,
    REG_STUCK_LIM  = 3'd4,
    REG_KEY_CODES  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] press_debounce_ms;
    logic [15:0] release_debounce_ms;
    logic        ghost_check_on;
    logic        stuck_check_on;
    logic [31:0] stuck_limit_ms;
    logic [63:0] key_codes;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  column_levels;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    ev_kind_t    event_kind;
    logic [3:0]  key_code;
    logic [1:0]  key_row;
    logic [1:0]  key_col;
    logic [31:0] stamp_ms;
    logic        last_of_scan;
  } out_t;

  typedef st_t [COLS-1:0]               row_st_t;
  typedef logic [COLS-1:0][31:0]        row_ct_t;
  typedef logic [ROWS-1:0][COLS-1:0]    down_map_t;
  typedef out_t [COLS-1:0]              ev_slots_t;

  // row-major key number, nibble select into key_codes
  function automatic logic [3:0] key_index(input logic [RW-1:0] r, input logic [RW-1:0] c);
    logic [4:0] t;
    t = 5'(r) * 5'(COLS) + 5'(c);
    return t[3:0];
  endfunction

endpackage

/* src/kms_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_cfg_regs
// Configuration register file, written one word per handshake.
// ----------------------------------------------------------------------------
module kms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output kms_pkg::cfg_t                   cfg_o
);
  import kms_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRESS_DB:   cfg_nxt.press_debounce_ms   = cfg_wdata[15:0];
        REG_RELEASE_DB: cfg_nxt.release_debounce_ms = cfg_wdata[15:0];
        REG_GHOST_ON:   cfg_nxt.ghost_check_on      = cfg_wdata[0];
        REG_STUCK_ON:   cfg_nxt.stuck_check_on      = cfg_wdata[0];
        REG_STUCK_LIM:  cfg_nxt.stuck_limit_ms      = cfg_wdata[31:0];
        REG_KEY_CODES:  cfg_nxt.key_codes           = cfg_wdata;
        default: ;      // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_debounce_ms   <= PRESS_DB_RST;
      cfg_r.release_debounce_ms <= RELEASE_DB_RST;
      cfg_r.ghost_check_on      <= 1'b1;
      cfg_r.stuck_check_on      <= 1'b1;
      cfg_r.stuck_limit_ms      <= STUCK_LIM_RST;
      cfg_r.key_codes           <= KEY_CODES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/kms_row_logic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_row_logic
// Debounce step for every key of the scanned row, with ghost and stuck checks.
// ----------------------------------------------------------------------------
module kms_row_logic (
  input  kms_pkg::cfg_t              cfg_i,
  input  logic [kms_pkg::RW-1:0]     row_i,
  input  kms_pkg::in_t               scan_i,
  input  kms_pkg::row_st_t           st_i,
  input  kms_pkg::row_ct_t           ct_i,
  input  kms_pkg::down_map_t         down_i,
  output kms_pkg::row_st_t           st_nxt_o,
  output kms_pkg::row_ct_t           ct_nxt_o,
  output kms_pkg::down_map_t         down_nxt_o,
  output kms_pkg::ev_slots_t         ev_o,
  output logic [kms_pkg::COLS-1:0]   ev_vld_o
);
  import kms_pkg::*;

  st_t [COLS-1:0]   st_cur;
  logic [COLS-1:0]  pressed;
  logic [COLS-1:0]  press_due;
  logic [COLS-1:0]  rel_due;
  logic [COLS-1:0]  stuck_due;
  logic [COLS-1:0]  ghost;
  logic [31:0]      now;

  assign now = scan_i.time_ms;

  // elapsed-time checks, one per column
  always_comb begin
    logic [31:0] age;
    for (int c = 0; c < COLS; c++) begin
      age          = now - ct_i[c];
      pressed[c]   = ~scan_i.column_levels[c];
      st_cur[c]    = (st_i[c] > ST_REL_PEND) ? ST_IDLE : st_i[c];
      press_due[c] = age >= {16'd0, cfg_i.press_debounce_ms};
      rel_due[c]   = age >= {16'd0, cfg_i.release_debounce_ms};
      stuck_due[c] = cfg_i.stuck_check_on && (age > cfg_i.stuck_limit_ms);
    end
  end

  // next state; down map runs column by column so ghost sees earlier columns
  always_comb begin
    down_map_t  dm;
    logic [2:0] in_row;
    logic [2:0] in_col;
    dm       = down_i;
    st_nxt_o = st_cur;
    ct_nxt_o = ct_i;
    ghost    = '0;
    for (int c = 0; c < COLS; c++) begin
      in_row = '0;
      in_col = '0;
      for (int i = 0; i < COLS; i++) in_row = in_row + 3'(dm[row_i][i]);
      for (int i = 0; i < ROWS; i++) in_col = in_col + 3'(dm[i][c]);
      ghost[c] = cfg_i.ghost_check_on && (in_row >= 3'd2) && (in_col >= 3'd2);
      if (pressed[c]) begin
        unique case (st_cur[c])
          ST_IDLE: begin
            st_nxt_o[c] = ST_PRESS_PEND;
            ct_nxt_o[c] = now;
          end
          ST_PRESS_PEND: begin
            if (press_due[c] && !ghost[c]) begin
              st_nxt_o[c]  = ST_PRESSED;
              dm[row_i][c] = 1'b1;
            end
          end
          ST_PRESSED:  st_nxt_o[c] = ST_HELD;
          ST_REL_PEND: st_nxt_o[c] = ST_HELD;
          default: ;   // held stays held
        endcase
      end else begin
        unique case (st_cur[c])
          ST_PRESSED, ST_HELD: begin
            st_nxt_o[c] = ST_REL_PEND;
            ct_nxt_o[c] = now;
          end
          ST_REL_PEND: begin
            if (rel_due[c]) begin
              st_nxt_o[c]  = ST_IDLE;
              dm[row_i][c] = 1'b0;
            end
          end
          default: st_nxt_o[c] = ST_IDLE;
        endcase
      end
    end
    down_nxt_o = dm;
  end

  // events
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      ev_vld_o[c]          = 1'b0;
      ev_o[c].event_kind   = EV_PRESS;
      ev_o[c].key_code     = cfg_i.key_codes[{key_index(row_i, RW'(c)), 2'b00} +: 4];
      ev_o[c].key_row      = row_i;
      ev_o[c].key_col      = RW'(c);
      ev_o[c].stamp_ms     = now;
      ev_o[c].last_of_scan = 1'b0;
      if (pressed[c]) begin
        unique case (st_cur[c])
          ST_PRESS_PEND: begin
            ev_vld_o[c]        = press_due[c];
            ev_o[c].event_kind = ghost[c] ? EV_GHOST : EV_PRESS;
          end
          ST_PRESSED: begin
            ev_vld_o[c]        = stuck_due[c];
            ev_o[c].event_kind = EV_STUCK;
          end
          default: ;
        endcase
      end else if (st_cur[c] == ST_REL_PEND) begin
        ev_vld_o[c]        = rel_due[c];
        ev_o[c].event_kind = EV_RELEASE;
      end
    end
  end

endmodule

/* src/kms_event_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_event_buf
// Holds the events of one scan and hands them out one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module kms_event_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load_i,
  input  kms_pkg::ev_slots_t          ev_i,
  input  logic [kms_pkg::COLS-1:0]    ev_vld_i,
  output logic                        free_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kms_pkg::out_t               out_word
);
  import kms_pkg::*;

  ev_slots_t        slot_r;
  logic [COLS-1:0]  pend_r;
  logic [COLS-1:0]  pend_nxt;
  logic [RW-1:0]    sel;
  logic             higher;

  // lowest pending column goes first; last when nothing above it is pending
  always_comb begin
    sel    = '0;
    higher = 1'b0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (pend_r[c]) sel = RW'(c);
    end
    for (int c = 0; c < COLS; c++) begin
      if (pend_r[c] && (RW'(c) > sel)) higher = 1'b1;
    end
  end

  assign out_valid = |pend_r;
  always_comb begin
    out_word              = slot_r[sel];
    out_word.last_of_scan = ~higher;
  end

  assign free_o = ~(|pend_r) | (out_ready & ~higher);

  always_comb begin
    pend_nxt = pend_r;
    if (out_valid && out_ready) pend_nxt[sel] = 1'b0;
    if (load_i) pend_nxt = ev_vld_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      slot_r <= ev_i;
    end
  end

`ifndef SYNTHESIS
  // a new scan never lands on events still owed
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> (!(|pend_r) || (out_ready && $onehot(pend_r))))
    else $error("event buffer overwritten");

  // a taken word that is not last leaves more behind
  a_more_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_word.last_of_scan && !load_i) |=> out_valid)
    else $error("scan events lost");
`endif

endmodule

/* src/keypad_matrix_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_scanner
// Debounced 4x4 key matrix scanner with ghost and stuck-key detection.
// ----------------------------------------------------------------------------
//  channel | ports                            | word
//  --------+----------------------------------+-------------------------------
//  in      | in_valid / in_ready / in_word    | column levels + ms time
//  out     | out_valid / out_ready / out_word | one key event
//  cfg     | cfg_valid / cfg_ready            | cfg_index selects, cfg_wdata
//
//  A scan waits in the input register, is resolved from there into the
//  event buffer, and its events leave one per cycle while out_ready is high.
//  Scans with no events are taken every cycle; a scan with events (at most
//  four) holds the next until its last event leaves the single output port.
//  rst_n is synchronous: all keys idle, row 0, registers at defaults.
//  Back-pressure on out stops draining; the input register then fills and
//  in_ready drops.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kms_pkg::in_t                    in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kms_pkg::out_t                   out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kms_pkg::*;

  cfg_t cfg;

  // input register
  in_t   in_r;
  logic  in_vld_r;
  logic  in_vld_nxt;

  // scanner state: per key debounce state and change time, down map, row
  row_st_t [ROWS-1:0] st_r;
  row_ct_t [ROWS-1:0] ct_r;
  down_map_t          down_r;
  logic [RW-1:0]      row_r;
  logic [RW-1:0]      row_nxt;

  row_st_t            st_row_nxt;
  row_ct_t            ct_row_nxt;
  down_map_t          down_nxt;
  ev_slots_t          ev;
  logic [COLS-1:0]    ev_vld;

  logic               buf_free;
  logic               take;    // scan in the input register is resolved now

  kms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  kms_row_logic u_row (
    .cfg_i      (cfg),
    .row_i      (row_r),
    .scan_i     (in_r),
    .st_i       (st_r[row_r]),
    .ct_i       (ct_r[row_r]),
    .down_i     (down_r),
    .st_nxt_o   (st_row_nxt),
    .ct_nxt_o   (ct_row_nxt),
    .down_nxt_o (down_nxt),
    .ev_o       (ev),
    .ev_vld_o   (ev_vld)
  );

  kms_event_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (take),
    .ev_i      (ev),
    .ev_vld_i  (ev_vld),
    .free_o    (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign take     = in_vld_r & buf_free;
  assign in_ready = ~in_vld_r | take;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) in_vld_nxt = 1'b0;
    if (in_valid && in_ready) in_vld_nxt = 1'b1;
  end

  // row counter wraps at ROWS
  assign row_nxt = (row_r == RW'(ROWS - 1)) ? '0 : row_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      row_r    <= '0;
      down_r   <= '0;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          st_r[r][c] <= ST_IDLE;
          ct_r[r][c] <= '0;
        end
      end
    end else begin
      in_vld_r <= in_vld_nxt;
      if (take) begin
        row_r        <= row_nxt;
        down_r       <= down_nxt;
        st_r[row_r]  <= st_row_nxt;
        ct_r[row_r]  <= ct_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_word;
    end
  end

`ifndef SYNTHESIS
  // a press leaving the block refers to a key that is marked down
  a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.event_kind == EV_PRESS) |->
      down_r[out_word.key_row][out_word.key_col[RW-1:0]])
    else $error("press event for key not marked down");

  // a release leaving the block refers to a key that is marked up
  a_release_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.event_kind == EV_RELEASE) |->
      !down_r[out_word.key_row][out_word.key_col[RW-1:0]])
    else $error("release event for key still down");

  // row counter stays in range
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= RW'(ROWS - 1))
    else $error("active row out of range");

  // an unresolved scan is kept
  a_scan_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !take) |=> (in_vld_r && $stable(in_r)))
    else $error("pending scan dropped");
`endif

endmodule
